/* rtl/osfm_pkg.sv */
// Package with the types and constants of the overlay scale factor mapper.
package osfm_pkg;

  // Width of the source and destination size fields.
  localparam int unsigned SizeW = 12;
  // Width of the zoom fraction and number of quotient bits taken per item.
  localparam int unsigned FracW = 11;
  // Largest divider exponent (divider 16) and the matching minify code.
  localparam logic [2:0] DivExpMax = 3'd4;
  localparam logic [2:0] MinCodeMax = 3'd7;
  // Mask that keeps the fetch alignment to its four bits.
  localparam logic [3:0] AlignMask = 4'hf;

  typedef struct packed {
    logic             kind;
    logic [SizeW-1:0] source_size;
    logic [SizeW-1:0] dest_size;
  } osfm_in_t;

  typedef struct packed {
    logic [FracW-1:0] scale_factor;
    logic             scale_enable;
    logic             interpolate;
    logic [2:0]       minify_code;
    logic [3:0]       fetch_align;
    logic [SizeW-1:0] display_count;
    logic             ok;
  } osfm_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_DIV,
    ST_FIN
  } osfm_state_e;

endpackage

/* rtl/overlay_scale_factor_mapper_unit.sv */
// Overlay scale factor mapper: one axis of overlay scaler settings per transfer.

// One transfer in gives one transfer out. An item is taken only while the unit
// is idle; it then works through the item one step per cycle, but waits in the
// last step while the output register is still held. A downscale first halves
// the source once per cycle until it fits the destination, with at most four
// halvings (divider 2 to 16). Any zoom fraction then comes from a restoring
// divider that produces one quotient bit per cycle, eleven bits in all. A last
// step loads the output register. The output register holds a finished result
// while the next item is taken in.

module overlay_scale_factor_mapper_unit
  import osfm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  osfm_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output osfm_out_t out_data_o
);

  localparam logic [3:0] LastStep = 4'(FracW - 1);

  osfm_state_e      state_q, state_d;
  logic             kind_q, kind_d;
  logic [SizeW-1:0] src_q, src_d;
  logic [SizeW-1:0] dst_q, dst_d;
  logic [SizeW-1:0] shf_q, shf_d;
  logic [2:0]       dexp_q, dexp_d;
  logic [SizeW-1:0] rem_q, rem_d;
  logic [FracW-1:0] quo_q, quo_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             minify_q, minify_d;
  logic             okf_q, okf_d;
  logic             dodiv_q, dodiv_d;
  logic             out_valid_q, out_valid_d;
  osfm_out_t        out_q, out_d;

  logic [SizeW:0]   rem2;
  logic [SizeW-1:0] num;
  logic [4:0]       divider;
  logic [5:0]       align_full;
  logic [3:0]       code_full;
  logic             out_free;

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    shf_q    <= shf_d;
    dexp_q   <= dexp_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    cnt_q    <= cnt_d;
    minify_q <= minify_d;
    okf_q    <= okf_d;
    dodiv_q  <= dodiv_d;
    out_q    <= out_d;
  end

  // Helper values for the divider step and the final settings.
  always_comb begin
    rem2       = {rem_q, 1'b0};
    num        = kind_q ? ((shf_q >= SizeW'(2)) ? shf_q - SizeW'(2) : '0) : shf_q;
    divider    = minify_q ? (5'd1 << dexp_q) : 5'd1;
    align_full = {divider, 1'b0} - 6'd1;
    code_full  = {dexp_q, 1'b0} - 4'd1;
    out_free   = !out_valid_q || !out_stall_i;
  end

  // Next state and outputs of the sequencer.
  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    src_d       = src_q;
    dst_d       = dst_q;
    shf_d       = shf_q;
    dexp_d      = dexp_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    minify_d    = minify_q;
    okf_d       = okf_q;
    dodiv_d     = dodiv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = (state_q != ST_IDLE);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          kind_d   = in_data_i.kind;
          src_d    = in_data_i.source_size;
          dst_d    = in_data_i.dest_size;
          shf_d    = in_data_i.source_size >> 1;
          dexp_d   = 3'd1;
          rem_d    = in_data_i.source_size;
          quo_d    = '0;
          cnt_d    = '0;
          minify_d = 1'b0;
          okf_d    = 1'b1;
          dodiv_d  = 1'b0;
          if (in_data_i.source_size < in_data_i.dest_size) begin
            dodiv_d = 1'b1;
            state_d = ST_DIV;
          end else if (in_data_i.source_size > in_data_i.dest_size) begin
            minify_d = 1'b1;
            state_d  = ST_SHIFT;
          end else begin
            state_d = ST_FIN;
          end
        end
      end

      // One halving of the source per cycle until it fits or the limit is hit.
      ST_SHIFT: begin
        if (shf_q <= dst_q || dexp_q == DivExpMax) begin
          okf_d = (shf_q <= dst_q);
          if (shf_q < dst_q) begin
            rem_d   = num;
            dodiv_d = 1'b1;
            state_d = ST_DIV;
          end else begin
            state_d = ST_FIN;
          end
        end else begin
          shf_d  = shf_q >> 1;
          dexp_d = dexp_q + 3'd1;
        end
      end

      // One restoring quotient bit per cycle; the remainder stays below dest.
      ST_DIV: begin
        if (rem2 >= {1'b0, dst_q}) begin
          rem_d = SizeW'(rem2 - {1'b0, dst_q});
          quo_d = {quo_q[FracW-2:0], 1'b1};
        end else begin
          rem_d = SizeW'(rem2);
          quo_d = {quo_q[FracW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == LastStep) begin
          state_d = ST_FIN;
        end
      end

      // Load the result once the output register is free.
      ST_FIN: begin
        if (out_free) begin
          out_d.scale_factor  = dodiv_q ? (kind_q ? quo_q : {1'b0, quo_q[FracW-1:1]}) : '0;
          out_d.scale_enable  = dodiv_q;
          out_d.interpolate   = dodiv_q || (minify_q && kind_q);
          out_d.minify_code   = minify_q ? code_full[2:0] : 3'd0;
          out_d.fetch_align   = (minify_q && kind_q) ? (align_full[3:0] & AlignMask) : 4'd0;
          out_d.display_count = kind_q ?
            ((src_q >= SizeW'(divider)) ? src_q - SizeW'(divider) : '0) : '0;
          out_d.ok            = okf_q;
          out_valid_d         = 1'b1;
          state_d             = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A failed fit always comes with the largest divider.
  a_fail_max_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.minify_code == MinCodeMax)
    else $error("failed fit without divider 16");

  // No fraction is given while zoom is off.
  a_factor_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.scale_enable |-> out_data_o.scale_factor == '0)
    else $error("zoom fraction without zoom enable");

  // The partial remainder stays below the destination during division.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < dst_q)
    else $error("divider remainder out of range");

  // The quotient loop never runs past its last bit.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q <= LastStep)
    else $error("divider step count overrun");

endmodule

/* dv/osfm_checker.sv */
// Checker that predicts and compares the overlay scale factor mapper transfers.
`timescale 1ns / 1ps

module osfm_checker
  import osfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  osfm_in_t    in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  osfm_out_t   out_data_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_count_o
);

  // Settings still owed by the unit, oldest first.
  osfm_out_t   expected_settings[$];
  int unsigned mismatch_count = 0;
  int unsigned pending_count = 0;

  assign mismatch_count_o = mismatch_count;
  assign pending_count_o  = pending_count;

  // Work out the scaler settings of one axis from its source and destination sizes.
  function automatic osfm_out_t predict_axis_settings(osfm_in_t item);
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] shifted;
    logic [31:0] numer;
    logic [31:0] unity;
    logic [31:0] frac_mask;
    logic [31:0] divider;
    int unsigned div_exp;
    logic        fits;
    osfm_out_t   res;
    src       = 32'(item.source_size);
    dst       = 32'(item.dest_size);
    unity     = item.kind ? 32'h800 : 32'h400;
    frac_mask = item.kind ? 32'h7ff : 32'h3ff;
    res       = '0;
    res.ok    = 1'b1;
    divider   = 32'd1;
    if (src < dst) begin
      // Upscale: plain fraction, zoom and interpolation on.
      res.scale_factor = FracW'(((src * unity) / dst) & frac_mask);
      res.scale_enable = 1'b1;
      res.interpolate  = 1'b1;
    end else if (src > dst) begin
      // Downscale: halve until the source fits, giving up at a divider of 16.
      shifted = src;
      fits    = 1'b0;
      div_exp = 0;
      for (int e = 1; e <= 4; e++) begin
        if (!fits) begin
          shifted = shifted >> 1;
          div_exp = e;
          fits    = (shifted <= dst);
        end
      end
      if (!fits) res.ok = 1'b0;
      res.minify_code = 3'(2 * div_exp - 1);
      divider = 32'd1 << div_exp;
      if (item.kind) begin
        res.fetch_align = 4'((2 * divider - 1) & 32'(AlignMask));
        res.interpolate = 1'b1;
      end
      // Residual zoom when the halved source falls short of the destination.
      if (shifted < dst) begin
        numer = shifted;
        if (item.kind) numer = (shifted >= 32'd2) ? shifted - 32'd2 : 32'd0;
        res.scale_factor = FracW'(((numer * unity) / dst) & frac_mask);
        res.scale_enable = 1'b1;
        res.interpolate  = 1'b1;
      end
    end
    if (item.kind) res.display_count = (src >= divider) ? SizeW'(src - divider) : '0;
    return res;
  endfunction

  // Compare one field of a result and report it when it differs.
  task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  // Retire a result transfer against the oldest expectation, then record a new input
  // transfer. A result can never belong to an input accepted at the same edge.
  always @(posedge clk_i) begin
    osfm_out_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_settings.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result transfer, expected none, actual %h", $time,
                   out_data_i);
        end else begin
          want = expected_settings.pop_front();
          check_field("scale_factor", 32'(want.scale_factor), 32'(out_data_i.scale_factor));
          check_field("scale_enable", 32'(want.scale_enable), 32'(out_data_i.scale_enable));
          check_field("interpolate", 32'(want.interpolate), 32'(out_data_i.interpolate));
          check_field("minify_code", 32'(want.minify_code), 32'(out_data_i.minify_code));
          check_field("fetch_align", 32'(want.fetch_align), 32'(out_data_i.fetch_align));
          check_field("display_count", 32'(want.display_count),
                      32'(out_data_i.display_count));
          check_field("ok", 32'(want.ok), 32'(out_data_i.ok));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_settings.push_back(predict_axis_settings(in_data_i));
      end
    end
    pending_count = expected_settings.size();
  end

endmodule

/* dv/testbench.sv */
// Top of the overlay scale factor mapper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import osfm_pkg::*;

  // Far above the slowest correct run of all phases.
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemsPerPhase = 382;
  localparam int unsigned TailCycles = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  osfm_in_t    in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  osfm_out_t   out_data;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned cycle_count = 0;
  int unsigned idle_pct;
  int unsigned stall_pct;

  overlay_scale_factor_mapper_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  osfm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Give up on a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Offer one size pair, idling first at the phase rate, and hold it until taken.
  task automatic send_size_pair(logic kind, int unsigned src, int unsigned dst);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid              <= 1'b1;
    in_data.kind          <= kind;
    in_data.source_size   <= SizeW'(src);
    in_data.dest_size     <= SizeW'(dst);
    do @(posedge clk_i); while (in_stall);
  endtask

  // Random size pairs, weighted toward each scaling regime.
  task automatic send_random_pair();
    int unsigned src;
    int unsigned dst;
    int unsigned hi;
    case ($urandom_range(9))
      0: begin
        src = $urandom_range(4095);
        dst = src;
      end
      1, 2: begin
        dst = $urandom_range(4095, 1);
        src = $urandom_range(dst - 1, 0);
      end
      3, 4, 5: begin
        // Downscale that fits within a divider of 16.
        dst = $urandom_range(255, 1);
        hi  = dst * 16 + 15;
        if (hi > 4095) hi = 4095;
        src = $urandom_range(hi, dst + 1);
      end
      6: begin
        // Downscale beyond a divider of 16.
        dst = $urandom_range(254);
        src = $urandom_range(4095, dst * 16 + 16);
      end
      7: begin
        src = $urandom_range(40);
        dst = $urandom_range(40);
      end
      default: begin
        src = $urandom_range(4095);
        dst = $urandom_range(4095);
      end
    endcase
    send_size_pair(1'($urandom_range(1)), src, dst);
  endtask

  // Hold the input quiet until every transfer has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_tab[4];
    int unsigned stall_tab[4];
    idle_tab    = '{0, 62, 0, 35};
    stall_tab   = '{0, 0, 62, 35};
    idle_pct    = 0;
    stall_pct   = 0;
    rst_ni    <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs: size extremes, zero sizes and each regime on both axes.
    send_size_pair(1'b0, 0, 0);
    send_size_pair(1'b1, 0, 0);
    send_size_pair(1'b0, 4095, 4095);
    send_size_pair(1'b1, 4095, 4095);
    send_size_pair(1'b0, 0, 4095);
    send_size_pair(1'b1, 0, 4095);
    send_size_pair(1'b0, 1, 4095);
    send_size_pair(1'b1, 4094, 4095);
    send_size_pair(1'b0, 4095, 0);
    send_size_pair(1'b1, 4095, 0);
    send_size_pair(1'b0, 4095, 1);
    send_size_pair(1'b1, 4095, 1);
    send_size_pair(1'b1, 1, 0);
    send_size_pair(1'b0, 1, 0);
    send_size_pair(1'b0, 200, 100);
    send_size_pair(1'b1, 200, 100);
    send_size_pair(1'b0, 300, 100);
    send_size_pair(1'b1, 300, 100);
    send_size_pair(1'b1, 3, 2);
    send_size_pair(1'b1, 700, 100);
    send_size_pair(1'b0, 1500, 100);
    send_size_pair(1'b1, 1600, 100);
    send_size_pair(1'b1, 4095, 255);
    send_size_pair(1'b0, 2730, 2731);

    // Random phases with different idle and stall rates, drained in between.
    for (int p = 0; p < 4; p++) begin
      drain_results();
      idle_pct  = idle_tab[p];
      stall_pct <= stall_tab[p];
      for (int unsigned n = 0; n < ItemsPerPhase; n++) send_random_pair();
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* overlay_scale_factor_mapper_unit.f */
rtl/osfm_pkg.sv
rtl/overlay_scale_factor_mapper_unit.sv
dv/osfm_checker.sv
dv/testbench.sv
